// File: design/utd_pkg.sv
package utd_pkg;

  // class of one raw byte, decided by the front end
  typedef enum logic [1:0] {
    CLS_ASCII = 2'd0,
    CLS_CONT  = 2'd1,
    CLS_LEAD2 = 2'd2,
    CLS_LEAD3 = 2'd3
  } utd_class_e;

  // kind of sequence pending in the decoder
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TWO   = 2'd1,
    KIND_THREE = 2'd2
  } utd_kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_UNIT  = 2'd1,
    ST_ERROR = 2'd2
  } utd_status_e;

  // classified byte as it travels through the queue
  typedef struct packed {
    utd_class_e cls;
    logic [6:0] bits;
  } utd_item_t;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] LeadMask  = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;

  function automatic utd_class_e classify(logic [7:0] b);
    utd_class_e c;
    if (!b[7]) begin
      c = CLS_ASCII;
    end else if ((b & ContMask) == ContCode) begin
      c = CLS_CONT;
    end else if ((b & LeadMask) == Lead2Code) begin
      c = CLS_LEAD2;
    end else begin
      c = CLS_LEAD3;
    end
    return c;
  endfunction

endpackage

// File: design/utd_byte_if.sv
interface utd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// File: design/utd_result_if.sv
interface utd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] code_unit;

  modport source (output valid, output status, output code_unit, input ready);
  modport sink (input valid, input status, input code_unit, output ready);
endinterface

// File: design/utd_front.sv
module utd_front
  import utd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  utd_byte_if.sink  in_i,
  output logic      item_vld_o,
  input  logic      item_rdy_i,
  output utd_item_t item_o
);

  logic      vld_q, vld_d;
  utd_item_t item_q;
  logic      take;

  // stage empties when the queue takes its item, unless a new byte is taken in the same cycle
  assign in_i.ready = !vld_q || item_rdy_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (item_rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.cls  <= classify(in_i.in_byte);
      item_q.bits <= in_i.in_byte[6:0];
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

// File: design/utd_fifo.sv
module utd_fifo
  import utd_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_vld_i,
  output logic      wr_rdy_o,
  input  utd_item_t wr_item_i,
  output logic      rd_vld_o,
  input  logic      rd_rdy_i,
  output utd_item_t rd_item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  utd_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wr_rdy_o  = cnt_q != CntW'(Depth);
  assign rd_vld_o  = cnt_q != '0;
  assign push      = wr_vld_i && wr_rdy_o;
  assign pop       = rd_vld_o && rd_rdy_i;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// File: design/utd_back.sv
module utd_back
  import utd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        swap_bytes_we_i,
  input  logic        swap_bytes_i,
  input  logic        item_vld_i,
  output logic        item_rdy_o,
  input  utd_item_t   item_i,
  utd_result_if.source out_o
);

  logic        swap_q;
  utd_kind_e   kind_q, kind_d;
  logic        mid_q, mid_d;
  logic [15:0] part_q, part_d;
  logic        out_vld_q, out_vld_d;
  utd_status_e status_q, status_d;
  logic [15:0] unit_q, unit_d;
  logic [15:0] raw_unit;
  logic        step;
  logic [5:0]  low6;

  assign item_rdy_o = !out_vld_q || out_o.ready;
  assign step       = item_vld_i && item_rdy_o;
  assign low6       = item_i.bits[5:0];

  // next decoder state
  always_comb begin
    kind_d = kind_q;
    mid_d  = mid_q;
    part_d = part_q;
    unique case (item_i.cls)
      CLS_ASCII: begin
        kind_d = KIND_NONE;
        mid_d  = (kind_q == KIND_NONE) ? mid_q : 1'b0;
        part_d = '0;
      end
      CLS_CONT: begin
        if (kind_q == KIND_TWO || (kind_q == KIND_THREE && mid_q)) begin
          kind_d = KIND_NONE;
          mid_d  = 1'b0;
          part_d = '0;
        end else if (kind_q == KIND_THREE) begin
          mid_d  = 1'b1;
          part_d = part_q | {4'b0, low6, 6'b0};
        end
      end
      CLS_LEAD2: begin
        kind_d = KIND_TWO;
        mid_d  = 1'b0;
        part_d = {5'b0, item_i.bits[4:0], 6'b0};
      end
      CLS_LEAD3: begin
        kind_d = KIND_THREE;
        mid_d  = 1'b0;
        part_d = {item_i.bits[3:0], 12'b0};
      end
      default: begin
        kind_d = kind_q;
      end
    endcase
  end

  // result of this byte
  always_comb begin
    status_d = ST_NONE;
    raw_unit = '0;
    unique case (item_i.cls)
      CLS_ASCII: begin
        if (kind_q != KIND_NONE) begin
          status_d = ST_ERROR;
        end else begin
          status_d = ST_UNIT;
          raw_unit = {9'b0, item_i.bits};
        end
      end
      CLS_CONT: begin
        if (kind_q == KIND_TWO || (kind_q == KIND_THREE && mid_q)) begin
          status_d = ST_UNIT;
          raw_unit = part_q | {10'b0, low6};
        end else if (kind_q != KIND_THREE) begin
          status_d = ST_ERROR;
        end
      end
      CLS_LEAD2, CLS_LEAD3: begin
        status_d = (kind_q != KIND_NONE) ? ST_ERROR : ST_NONE;
      end
      default: begin
        status_d = ST_NONE;
      end
    endcase
    unit_d = swap_q ? {raw_unit[7:0], raw_unit[15:8]} : raw_unit;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q    <= 1'b1;
      kind_q    <= KIND_NONE;
      mid_q     <= 1'b0;
      part_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (swap_bytes_we_i) begin
        swap_q <= swap_bytes_i;
      end
      if (step) begin
        kind_q <= kind_d;
        mid_q  <= mid_d;
        part_q <= part_d;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      status_q <= status_d;
      unit_q   <= unit_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.status    = status_q;
  assign out_o.code_unit = unit_q;

endmodule

// File: design/utf8_to_ucs2_decoder.sv
// channel   direction  width  contents
// in_i      sink       8      in_byte, one raw utf-8 byte per transaction
// out_o     source     2+16   status, code_unit (one result per input byte)
// swap_*    write      1      swap_bytes register, reset 1
//
// throughput is one byte per cycle while the sink does not stall; an accepted byte
// passes the classify register, the queue and the decoder/result register in turn
// the decoder state update in the back end is the loop that sets the throughput
// asynchronous active-low reset clears state, the queue and swap_bytes to 1
// either side may stall: the queue lets the front keep taking bytes while the
// result register waits on a stalled sink
module utf8_to_ucs2_decoder
  import utd_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         swap_bytes_we_i,
  input  logic         swap_bytes_i,
  utd_byte_if.sink     in_i,
  utd_result_if.source out_o
);

  // front end to queue
  logic      fr_vld, fr_rdy;
  utd_item_t fr_item;
  // queue to back end
  logic      q_vld, q_rdy;
  utd_item_t q_item;

  // front: register and classify each accepted byte
  utd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .item_vld_o (fr_vld),
    .item_rdy_i (fr_rdy),
    .item_o     (fr_item)
  );

  // short queue decoupling classification from decoding
  utd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_vld_i  (fr_vld),
    .wr_rdy_o  (fr_rdy),
    .wr_item_i (fr_item),
    .rd_vld_o  (q_vld),
    .rd_rdy_i  (q_rdy),
    .rd_item_o (q_item)
  );

  // back: sequence state, code unit assembly, byte swap, result register
  utd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .swap_bytes_we_i (swap_bytes_we_i),
    .swap_bytes_i    (swap_bytes_i),
    .item_vld_i      (q_vld),
    .item_rdy_o      (q_rdy),
    .item_i          (q_item),
    .out_o           (out_o)
  );

  // a byte taken at the input sits in the front register next cycle
  a_front_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> fr_vld)
    else $error("accepted byte lost in front stage");

  // a classified byte blocked by a full queue stays put
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_vld && !fr_rdy) |=> (fr_vld && $stable(fr_item)))
    else $error("front item dropped while queue full");

  // only a code unit result carries a nonzero value
  a_unit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_UNIT) |-> (out_o.code_unit == '0))
    else $error("code unit set on a non-unit result");

  // no unused status code appears
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status == ST_NONE || out_o.status == ST_UNIT ||
                     out_o.status == ST_ERROR))
    else $error("illegal status code");

endmodule
